>>> design/sorted_set_engine_top_macros.svh
// Assertion helpers for the sorted set engine.
// Each expects clk and arst_n in the enclosing scope.
`ifndef SORTED_SET_ENGINE_TOP_MACROS_SVH
`define SORTED_SET_ENGINE_TOP_MACROS_SVH

// cond must hold at every edge outside reset
`define SSE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sse_pkg.sv
`default_nettype none
package sse_pkg;

	localparam int DEFAULT_CAPACITY = 64;

	// request operation codes
	localparam logic [2:0] FUNC_ADD     = 3'd0;
	localparam logic [2:0] FUNC_REMOVE  = 3'd1;
	localparam logic [2:0] FUNC_MEMBER  = 3'd2;
	localparam logic [2:0] FUNC_EXT_MIN = 3'd3;
	localparam logic [2:0] FUNC_EXT_MAX = 3'd4;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_MISS  = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_EMPTY = 2'd3;

	typedef struct packed {
		logic        [2:0]  func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] value_out;
		logic        [6:0]  count;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
	} rsp_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_CMP,
		CMD_INS,
		CMD_DEL,
		CMD_SHL
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic signed [31:0] value;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

>>> design/sse_cell.sv
`default_nettype none
// One slot of the sorted row. Compares against the broadcast value, then
// shifts toward or away from its neighbors.
module sse_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire sse_pkg::cell_ctrl_t  ctrl,
	input  wire logic [CW-1:0]        count,
	input  wire logic                 left_lt,
	input  wire logic signed [31:0]   left_elem,
	input  wire logic signed [31:0]   right_elem,
	output logic signed [31:0]        elem,
	output logic                      lt,
	output logic                      eq
);

	logic signed [31:0] elem_q;
	logic               lt_q;
	logic               eq_q;
	logic               occ;

	assign occ  = CW'(IDX) < count;
	assign elem = elem_q;
	assign lt   = lt_q;
	assign eq   = eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.cmd == sse_pkg::CMD_CMP) begin
			lt_q <= occ && (elem_q < ctrl.value);
			eq_q <= occ && (elem_q == ctrl.value);
		end
	end

	// slot contents carry no reset
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			sse_pkg::CMD_INS: begin
				if (!lt_q)
					elem_q <= left_lt ? ctrl.value : left_elem;
			end
			sse_pkg::CMD_DEL: begin
				if (!lt_q)
					elem_q <= right_elem;
			end
			sse_pkg::CMD_SHL: elem_q <= right_elem;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> design/sorted_set_engine_top.sv
// Sorted set engine: each accepted request passes the compare, apply and finish
// states before its response is registered; a new request is taken only back in idle,
// set by the compare-then-shift sequence through the cell row.
// A full response register lets a new request in while the last waits.
// Reset (async, active low) empties the set; slot contents are not cleared.
`default_nettype none
`include "sorted_set_engine_top_macros.svh"
module sorted_set_engine_top #(
	parameter int CAPACITY = sse_pkg::DEFAULT_CAPACITY
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          req_valid,
	output logic         req_ready,
	input  wire sse_pkg::req_t req,
	output logic         rsp_valid,
	input  wire          rsp_ready,
	output sse_pkg::rsp_t rsp
);

	// count needs to hold CAPACITY itself
	localparam int CW = $clog2(CAPACITY + 1);

	sse_pkg::state_t     state_q, state_d;
	sse_pkg::req_t       req_q;
	sse_pkg::cell_ctrl_t cell_ctrl;
	sse_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;
	logic                rsp_load;

	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       last_idx;
	logic [CW+6:0]       count_ext;
	logic [1:0]          status_q, status_d;
	logic signed [31:0]  taken_q, taken_d;
	logic signed [31:0]  last_q;      // largest element before the update
	logic signed [31:0]  last_elem;

	logic signed [31:0]  elem_arr [CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic                found;
	logic                full;
	logic                empty;

	// ------------------------------------------------------------------
	// Cell row. Occupied slots hold the set in ascending order from slot 0.
	// Insert: slots past the insert point take their left neighbor,
	// the insert point itself takes the request value.
	// Delete: slots at or past the hit take their right neighbor.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               l_lt;
		logic signed [31:0] l_elem;
		logic signed [31:0] r_elem;

		if (i == 0) begin : g_first
			assign l_lt   = 1'b1;
			assign l_elem = req_q.value;
		end else begin : g_mid
			assign l_lt   = lt_vec[i-1];
			assign l_elem = elem_arr[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_elem = elem_arr[i];
		end else begin : g_inner
			assign r_elem = elem_arr[i+1];
		end

		sse_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.count      (count_q),
			.left_lt    (l_lt),
			.left_elem  (l_elem),
			.right_elem (r_elem),
			.elem       (elem_arr[i]),
			.lt         (lt_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	// Top occupied slot, selected by one-hot match on count - 1.
	// Used on the old count in compare and the new count in finish.
	assign last_idx = count_q - CW'(1);

	always_comb begin
		last_elem = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CW'(i) == last_idx)
				last_elem = last_elem | elem_arr[i];
		end
	end

	assign found = |eq_vec;
	assign full  = count_q == CW'(CAPACITY);
	assign empty = count_q == '0;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sse_pkg::S_IDLE:  if (req_valid) state_d = sse_pkg::S_CMP;
			sse_pkg::S_CMP:   state_d = sse_pkg::S_APPLY;
			sse_pkg::S_APPLY: state_d = sse_pkg::S_FIN;
			sse_pkg::S_FIN:   if (!rsp_valid_q || rsp_ready) state_d = sse_pkg::S_IDLE;
			default:          state_d = sse_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready       = 1'b0;
		rsp_load        = 1'b0;
		cell_ctrl.cmd   = sse_pkg::CMD_HOLD;
		cell_ctrl.value = req_q.value;
		count_d         = count_q;
		status_d        = sse_pkg::STATUS_MISS;
		taken_d         = '0;
		unique case (state_q)
			sse_pkg::S_IDLE: req_ready = 1'b1;
			sse_pkg::S_CMP:  cell_ctrl.cmd = sse_pkg::CMD_CMP;
			sse_pkg::S_APPLY: begin
				unique case (req_q.func)
					sse_pkg::FUNC_ADD: begin
						// a duplicate reports a miss even when full
						if (found) begin
							status_d = sse_pkg::STATUS_MISS;
						end else if (full) begin
							status_d = sse_pkg::STATUS_FULL;
						end else begin
							cell_ctrl.cmd = sse_pkg::CMD_INS;
							count_d       = count_q + CW'(1);
							status_d      = sse_pkg::STATUS_OK;
						end
					end
					sse_pkg::FUNC_REMOVE: begin
						if (found) begin
							cell_ctrl.cmd = sse_pkg::CMD_DEL;
							count_d       = count_q - CW'(1);
							status_d      = sse_pkg::STATUS_OK;
						end
					end
					sse_pkg::FUNC_MEMBER: begin
						if (found)
							status_d = sse_pkg::STATUS_OK;
					end
					sse_pkg::FUNC_EXT_MIN: begin
						if (empty) begin
							status_d = sse_pkg::STATUS_EMPTY;
						end else begin
							cell_ctrl.cmd = sse_pkg::CMD_SHL;
							count_d       = count_q - CW'(1);
							status_d      = sse_pkg::STATUS_OK;
							taken_d       = elem_arr[0];
						end
					end
					sse_pkg::FUNC_EXT_MAX: begin
						// dropping the top slot only needs the count
						if (empty) begin
							status_d = sse_pkg::STATUS_EMPTY;
						end else begin
							count_d  = count_q - CW'(1);
							status_d = sse_pkg::STATUS_OK;
							taken_d  = last_q;
						end
					end
					default: status_d = sse_pkg::STATUS_MISS;
				endcase
			end
			sse_pkg::S_FIN: rsp_load = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sse_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// response count reported modulo 128
	assign count_ext = {7'd0, count_q};

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_q <= req;
		if (state_q == sse_pkg::S_CMP)
			last_q <= last_elem;
		if (state_q == sse_pkg::S_APPLY) begin
			status_q <= status_d;
			taken_q  <= taken_d;
		end
		if (rsp_load) begin
			rsp_q.status    <= status_q;
			rsp_q.value_out <= taken_q;
			rsp_q.count     <= count_ext[6:0];
			rsp_q.min_value <= empty ? 32'sd0 : elem_arr[0];
			rsp_q.max_value <= empty ? 32'sd0 : last_elem;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SSE_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "count above capacity")
	`SSE_ASSERT_ALWAYS(a_eq_onehot, (state_q != sse_pkg::S_APPLY) || $onehot0(eq_vec), "value matched in more than one slot")
	`SSE_ASSERT_ALWAYS(a_lt_prefix, (state_q != sse_pkg::S_APPLY) || ((lt_vec & (lt_vec + CAPACITY'(1))) == '0), "less-than flags not a prefix, row out of order")
	`SSE_ASSERT_NEXT(a_rsp_loaded, rsp_load, rsp_valid_q && (state_q == sse_pkg::S_IDLE), "finish did not post a response")

endmodule
`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
	import sse_pkg::*;

	localparam int CAPACITY = DEFAULT_CAPACITY;
	localparam int RANDOM_ITEMS = 650;
	// last stretch of the random part runs with no idling on either side
	localparam int CALM_ITEMS = 60;
	// receiver hold-off long enough to back the block up into its input
	localparam int LONG_HOLD = 300;
	localparam int LONG_HOLD_AT = 200;
	// worst case per request is a gap, the block's turn and a stall, over ~700
	// requests plus the long hold; this is several times that
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [31:0] INT_HI = 32'sh7fffffff;
	localparam logic signed [31:0] INT_LO = 32'sh80000000;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	// one line of the directed script; want is used only where typed is set
	typedef struct packed {
		req_t ask;
		logic typed;
		rsp_t want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// payload side info that travels with the request on the wire
	logic cur_typed;
	rsp_t cur_want;

	// predictor state: held values, ascending, no duplicates
	int held_set[$];
	// results owed by the block, oldest first
	rsp_t pending_results[$];

	int mismatches = 0;
	int cycle_count = 0;
	bit sender_idles;
	bit sink_idles;
	bit calm_tail;
	bit long_hold_due;

	sorted_set_engine_top #(.CAPACITY(CAPACITY)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Sorted set predictor: applies one request to held_set and returns the
	// response the block owes for it.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t o;
		int v;
		int pos;
		bit hit;
		o = '0;
		o.status = STATUS_MISS;
		v = r.value;
		pos = 0;
		// lower bound: first slot >= v
		while (pos < held_set.size() && held_set[pos] < v)
			pos++;
		hit = (pos < held_set.size()) && (held_set[pos] == v);
		case (r.func)
			FUNC_ADD: begin
				// a duplicate reports miss even on a full set
				if (hit)
					o.status = STATUS_MISS;
				else if (held_set.size() >= CAPACITY)
					o.status = STATUS_FULL;
				else begin
					held_set.insert(pos, v);
					o.status = STATUS_OK;
				end
			end
			FUNC_REMOVE: begin
				if (hit) begin
					held_set.delete(pos);
					o.status = STATUS_OK;
				end
			end
			FUNC_MEMBER: begin
				if (hit)
					o.status = STATUS_OK;
			end
			FUNC_EXT_MIN: begin
				if (held_set.size() == 0)
					o.status = STATUS_EMPTY;
				else begin
					o.value_out = held_set.pop_front();
					o.status = STATUS_OK;
				end
			end
			FUNC_EXT_MAX: begin
				if (held_set.size() == 0)
					o.status = STATUS_EMPTY;
				else begin
					o.value_out = held_set.pop_back();
					o.status = STATUS_OK;
				end
			end
			// unknown codes leave the set alone and report miss
			default: o.status = STATUS_MISS;
		endcase
		o.count = 7'(held_set.size());
		// min/max read as zero on an empty set
		if (held_set.size() > 0) begin
			o.min_value = held_set[0];
			o.max_value = held_set[held_set.size() - 1];
		end
		return o;
	endfunction

	// Random request shaped by phase: fill phases push the set to capacity,
	// drain phases empty it, mixed phases hover. Values favor held entries
	// and a narrow band so hits and duplicates are common.
	function automatic req_t pick_request(input phase_t ph);
		req_t r;
		int roll;
		int vpick;
		roll = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				if (roll < 70) r.func = FUNC_ADD;
				else if (roll < 78) r.func = FUNC_REMOVE;
				else if (roll < 88) r.func = FUNC_MEMBER;
				else if (roll < 93) r.func = FUNC_EXT_MIN;
				else if (roll < 98) r.func = FUNC_EXT_MAX;
				else r.func = 3'($urandom_range(5, 7));
			end
			PH_DRAIN: begin
				if (roll < 15) r.func = FUNC_ADD;
				else if (roll < 40) r.func = FUNC_REMOVE;
				else if (roll < 50) r.func = FUNC_MEMBER;
				else if (roll < 73) r.func = FUNC_EXT_MIN;
				else if (roll < 96) r.func = FUNC_EXT_MAX;
				else r.func = 3'($urandom_range(5, 7));
			end
			default: begin
				if (roll < 35) r.func = FUNC_ADD;
				else if (roll < 55) r.func = FUNC_REMOVE;
				else if (roll < 75) r.func = FUNC_MEMBER;
				else if (roll < 85) r.func = FUNC_EXT_MIN;
				else if (roll < 95) r.func = FUNC_EXT_MAX;
				else r.func = 3'($urandom_range(5, 7));
			end
		endcase
		vpick = $urandom_range(0, 99);
		if (vpick < 35 && held_set.size() > 0)
			r.value = held_set[$urandom_range(0, held_set.size() - 1)];
		else if (vpick < 60)
			r.value = $urandom_range(0, 96) - 48;
		else if (vpick < 70) begin
			case ($urandom_range(0, 3))
				0: r.value = INT_LO;
				1: r.value = INT_HI;
				2: r.value = 32'sd0;
				default: r.value = -32'sd1;
			endcase
		end else
			r.value = $urandom;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Scoreboard. Push happens before pop so a same-edge accept and
	// response can never underflow the queue.
	always @(posedge clk) begin : scoreboard
		rsp_t predicted;
		rsp_t want;
		if (arst_n && req_valid && req_ready) begin
			predicted = apply_request(req);
			pending_results.push_back(cur_typed ? cur_want : predicted);
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response: expected none, got %h", $time, rsp);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("value_out", want.value_out, rsp.value_out);
				check_field("count", 32'(want.count), 32'(rsp.count));
				check_field("min_value", want.min_value, rsp.min_value);
				check_field("max_value", want.max_value, rsp.max_value);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Response side: random stall bursts, the one long hold-off when the
	// sender asks for it, and steady ready in the calm tail.
	initial begin : sink
		int stall_left;
		int window;
		rsp_ready = 1'b1;
		sink_idles = 1'b1;
		stall_left = 0;
		window = 0;
		forever begin
			@(negedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if (sink_idles && !calm_tail && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 19);
			end
			// alternate stretches with and without stalls
			window++;
			if (window >= 97) begin
				window = 0;
				sink_idles = ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Drives one request from the current falling edge until accepted, then
	// maybe drops valid for a burst. Caller must be at a falling edge.
	task automatic offer(input req_t item, input logic typed, input rsp_t want);
		int gap;
		req_valid <= 1'b1;
		req <= item;
		cur_typed <= typed;
		cur_want <= want;
		do
			@(posedge clk);
		while (!req_ready);
		if (sender_idles && !calm_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Directed script: empty-set errors, both extremes, duplicate add,
	// unknown codes, front and middle removal, front insertion, extracts
	// down to empty. Typed rows are readable straight from the spec.
	script_row_t script [0:25];

	initial begin : stimulus
		req_t item;
		phase_t ph;
		int phase_left;
		int counted;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cur_typed = 1'b0;
		cur_want = '0;
		sender_idles = 1'b1;
		calm_tail = 1'b0;
		long_hold_due = 1'b0;

		script = '{
			'{'{FUNC_EXT_MIN, 32'sd0}, 1'b1, '{STATUS_EMPTY, 32'sd0, 7'd0, 32'sd0, 32'sd0}},
			'{'{FUNC_EXT_MAX, -32'sd1}, 1'b1, '{STATUS_EMPTY, 32'sd0, 7'd0, 32'sd0, 32'sd0}},
			'{'{FUNC_MEMBER, 32'sd0}, 1'b1, '{STATUS_MISS, 32'sd0, 7'd0, 32'sd0, 32'sd0}},
			'{'{FUNC_REMOVE, INT_HI}, 1'b1, '{STATUS_MISS, 32'sd0, 7'd0, 32'sd0, 32'sd0}},
			'{'{FUNC_ADD, INT_HI}, 1'b1, '{STATUS_OK, 32'sd0, 7'd1, INT_HI, INT_HI}},
			'{'{FUNC_ADD, INT_LO}, 1'b1, '{STATUS_OK, 32'sd0, 7'd2, INT_LO, INT_HI}},
			// duplicate add: miss, set unchanged
			'{'{FUNC_ADD, INT_HI}, 1'b1, '{STATUS_MISS, 32'sd0, 7'd2, INT_LO, INT_HI}},
			'{'{FUNC_ADD, 32'sd0}, 1'b0, '0},
			'{'{FUNC_ADD, -32'sd1}, 1'b0, '0},
			'{'{FUNC_ADD, 32'sh55555555}, 1'b0, '0},
			'{'{FUNC_ADD, 32'shaaaaaaaa}, 1'b0, '0},
			'{'{FUNC_MEMBER, -32'sd1}, 1'b0, '0},
			'{'{FUNC_MEMBER, 32'sd1}, 1'b0, '0},
			// unknown codes are ignored
			'{'{3'd5, 32'sd0}, 1'b0, '0},
			'{'{3'd6, -32'sd1}, 1'b0, '0},
			'{'{3'd7, 32'sh55555555}, 1'b0, '0},
			'{'{FUNC_REMOVE, 32'sd0}, 1'b0, '0},
			'{'{FUNC_REMOVE, INT_LO}, 1'b0, '0},
			'{'{FUNC_REMOVE, INT_LO}, 1'b0, '0},
			'{'{FUNC_EXT_MIN, 32'sd7}, 1'b0, '0},
			'{'{FUNC_EXT_MAX, 32'sd7}, 1'b0, '0},
			// new smallest value lands at the front
			'{'{FUNC_ADD, -32'sd2}, 1'b0, '0},
			'{'{FUNC_EXT_MAX, 32'sd0}, 1'b0, '0},
			'{'{FUNC_EXT_MAX, 32'sd0}, 1'b0, '0},
			'{'{FUNC_EXT_MIN, 32'sd0}, 1'b0, '0},
			'{'{FUNC_EXT_MIN, 32'sd0}, 1'b1, '{STATUS_EMPTY, 32'sd0, 7'd0, 32'sd0, 32'sd0}}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			@(negedge clk);
			offer(script[i].ask, script[i].typed, script[i].want);
		end

		// Random part. The opening phase is a long fill so the set hits
		// capacity (full and full-duplicate adds) early; later phases are
		// drawn at random. Ignored codes do not advance the count.
		ph = PH_FILL;
		phase_left = 100;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0: ph = PH_FILL;
					1: ph = PH_DRAIN;
					default: ph = PH_MIXED;
				endcase
				phase_left = $urandom_range(40, 120);
				sender_idles = ($urandom_range(0, 3) != 0);
			end
			if (counted == LONG_HOLD_AT)
				long_hold_due = 1'b1;
			if (counted >= RANDOM_ITEMS - CALM_ITEMS)
				calm_tail = 1'b1;
			@(negedge clk);
			item = pick_request(ph);
			offer(item, 1'b0, '0);
			if (item.func <= FUNC_EXT_MAX)
				counted++;
			phase_left--;
		end

		@(negedge clk);
		req_valid <= 1'b0;

		// drain outstanding responses, then allow for the block's latency
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
